[src/cdfs_pkg.sv]
package cdfs_pkg;

    localparam int DEPTH       = 1024;
    localparam int WEIGHT_BITS = 16;
    localparam int FRAC_BITS   = 24;

    localparam int TAB_W   = 26;                 // cumulative entry width
    localparam int CNT_W   = $clog2(DEPTH + 1);  // holds 0..DEPTH, also table address
    localparam int IDX_W   = $clog2(DEPTH);
    localparam int SAMP_W  = FRAC_BITS + 1;
    localparam int OP_W    = 3;
    localparam int STAT_W  = 3;
    localparam int DIV_SH  = TAB_W - FRAC_BITS;  // numerator bits above the quotient window
    localparam int DIV_CNT_W = $clog2(TAB_W + 1);

    localparam logic [TAB_W-1:0]  TAB_MAX  = {TAB_W{1'b1}};
    localparam logic [TAB_W-1:0]  ONE_Q    = TAB_W'(1) << FRAC_BITS;
    localparam logic [CNT_W-1:0]  DEPTH_C  = CNT_W'(DEPTH);

    localparam logic [OP_W-1:0] OP_CLEAR     = 3'd0;
    localparam logic [OP_W-1:0] OP_APPEND    = 3'd1;
    localparam logic [OP_W-1:0] OP_NORMALIZE = 3'd2;
    localparam logic [OP_W-1:0] OP_SAMPLE    = 3'd3;
    localparam logic [OP_W-1:0] OP_READ      = 3'd4;

    localparam logic [STAT_W-1:0] ST_OK    = 3'd0;
    localparam logic [STAT_W-1:0] ST_FULL  = 3'd1;
    localparam logic [STAT_W-1:0] ST_EMPTY = 3'd2;
    localparam logic [STAT_W-1:0] ST_ZERO  = 3'd3;
    localparam logic [STAT_W-1:0] ST_OOB   = 3'd4;
    localparam logic [STAT_W-1:0] ST_SAT   = 3'd5;

    typedef enum logic [4:0] {
        ACT_NONE,
        ACT_LOAD,
        ACT_CLEAR,
        ACT_RD_LAST,
        ACT_APPEND_WR,
        ACT_NORM_SUM,
        ACT_NORM_RD,
        ACT_NORM_DIV,
        ACT_NORM_WR,
        ACT_NORM_FIN,
        ACT_SRCH_INIT,
        ACT_SRCH_RD,
        ACT_SRCH_CMP,
        ACT_PICK_RD0,
        ACT_READ_RD0,
        ACT_PICK_RD1,
        ACT_PICK_W,
        ACT_REM_DIV,
        ACT_REM_SET,
        ACT_SET_FULL,
        ACT_SET_EMPTY,
        ACT_SET_OOB,
        ACT_SET_ZERO,
        ACT_RESULT
    } t_act;

    typedef struct packed {
        t_act act;
        logic s_ready;
    } t_cmd;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic cnt_zero;
        logic full;
        logic sum_zero;
        logic srch_done;
        logic norm_last;
        logic idx_oob;
        logic width_zero;
        logic div_done;
        logic out_free;
    } t_sts;

endpackage

[src/cdfs_div.sv]
module cdfs_div
    import cdfs_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [TAB_W-1:0] i_num,
    input  logic [TAB_W-1:0] i_den,
    output logic [TAB_W-1:0] o_quot,
    output logic             o_done
);

    // floor(num * 2^FRAC_BITS / den), saturated to all ones; one quotient bit a cycle
    logic                 r_busy, n_busy;
    logic                 r_done, n_done;
    logic [DIV_CNT_W-1:0] r_cnt, n_cnt;
    logic [TAB_W:0]       r_rem, n_rem;
    logic [TAB_W-1:0]     r_low, n_low;
    logic [TAB_W-1:0]     r_quot, n_quot;
    logic [TAB_W-1:0]     r_den, n_den;
    logic [TAB_W+1:0]     den_big;
    logic [TAB_W+1:0]     trial;

    assign den_big = {i_den, {DIV_SH{1'b0}}};
    assign trial   = {r_rem[TAB_W-1:0], r_low[TAB_W-1]} - {2'b00, r_den};

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_low  = r_low;
        n_quot = r_quot;
        n_den  = r_den;
        if (i_start) begin
            n_den = i_den;
            if ({2'b00, i_num} >= den_big) begin
                n_quot = TAB_MAX;
                n_done = 1'b1;
                n_busy = 1'b0;
            end else begin
                n_rem  = (TAB_W+1)'(i_num >> DIV_SH);
                n_low  = {i_num[DIV_SH-1:0], {FRAC_BITS{1'b0}}};
                n_cnt  = DIV_CNT_W'(TAB_W);
                n_busy = 1'b1;
            end
        end else if (r_busy) begin
            n_low = r_low << 1;
            if (!trial[TAB_W+1]) begin
                n_rem  = trial[TAB_W:0];
                n_quot = {r_quot[TAB_W-2:0], 1'b1};
            end else begin
                n_rem  = {r_rem[TAB_W-1:0], r_low[TAB_W-1]};
                n_quot = {r_quot[TAB_W-2:0], 1'b0};
            end
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == DIV_CNT_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_cnt  <= n_cnt;
        r_rem  <= n_rem;
        r_low  <= n_low;
        r_quot <= n_quot;
        r_den  <= n_den;
    end

    assign o_quot = r_quot;
    assign o_done = r_done;

endmodule

[src/cdfs_datapath.sv]
module cdfs_datapath
    import cdfs_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cmd               i_cmd,
    output t_sts               o_sts,
    input  logic [OP_W-1:0]    i_op,
    input  logic [WEIGHT_BITS-1:0] i_weight,
    input  logic [SAMP_W-1:0]  i_sample,
    input  logic [IDX_W-1:0]   i_eidx,
    input  logic               i_m_tready,
    output logic               o_valid,
    output logic [IDX_W-1:0]   o_chosen,
    output logic [TAB_W-1:0]   o_prob,
    output logic [SAMP_W-1:0]  o_remap,
    output logic [TAB_W-1:0]   o_total,
    output logic [CNT_W-1:0]   o_count,
    output logic               o_flag,
    output logic [STAT_W-1:0]  o_stat
);

    logic [TAB_W-1:0] r_mem [0:DEPTH];
    logic [TAB_W-1:0] r_rd;
    logic             r_rd_zero;

    logic [OP_W-1:0]        r_op;
    logic [WEIGHT_BITS-1:0] r_weight;
    logic [SAMP_W-1:0]      r_sample;
    logic [IDX_W-1:0]       r_eidx;
    logic [CNT_W-1:0]       r_count, r_i, r_lo, r_hi, r_mid, r_idx;
    logic                   r_flag;
    logic [TAB_W-1:0]       r_csum, r_lo_v, r_width;
    logic [IDX_W-1:0]       r_chosen;
    logic [TAB_W-1:0]       r_prob, r_total;
    logic [SAMP_W-1:0]      r_remap;
    logic [STAT_W-1:0]      r_stat;

    logic                   r_o_valid;
    logic [IDX_W-1:0]       r_o_chosen;
    logic [TAB_W-1:0]       r_o_prob, r_o_total;
    logic [SAMP_W-1:0]      r_o_remap;
    logic [CNT_W-1:0]       r_o_count;
    logic                   r_o_flag;
    logic [STAT_W-1:0]      r_o_stat;

    logic [TAB_W-1:0] rd_data;
    logic [CNT_W-1:0] rd_addr, wr_addr, mid_c, pm1, cm1, idx_c;
    logic [CNT_W:0]   lohi;
    logic [TAB_W-1:0] wr_data, width_c, num_c, div_num, div_den, quot;
    logic [TAB_W:0]   app_sum;
    logic             wr_en, div_start, div_done;

    assign rd_data = r_rd_zero ? '0 : r_rd;
    assign lohi    = {1'b0, r_lo} + {1'b0, r_hi};
    assign mid_c   = lohi[CNT_W:1];
    assign pm1     = (r_lo == '0) ? '0 : r_lo - 1'b1;
    assign cm1     = r_count - 1'b1;
    assign idx_c   = (pm1 > cm1) ? cm1 : pm1;
    assign app_sum = {1'b0, rd_data} + (TAB_W+1)'(r_weight);
    assign width_c = rd_data - r_lo_v;
    assign num_c   = ({1'b0, r_sample} > r_lo_v) ? {1'b0, r_sample} - r_lo_v : '0;

    always_comb begin
        case (i_cmd.act)
            ACT_NORM_RD:  rd_addr = r_i;
            ACT_SRCH_RD:  rd_addr = mid_c;
            ACT_PICK_RD0: rd_addr = idx_c;
            ACT_READ_RD0: rd_addr = CNT_W'(r_eidx);
            ACT_PICK_RD1: rd_addr = r_idx + 1'b1;
            default:      rd_addr = r_count;
        endcase
    end

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_count + 1'b1;
        wr_data = app_sum[TAB_W] ? TAB_MAX : app_sum[TAB_W-1:0];
        case (i_cmd.act)
            ACT_APPEND_WR: wr_en = 1'b1;
            ACT_NORM_WR: begin
                wr_en   = 1'b1;
                wr_addr = r_i;
                wr_data = quot;
            end
            ACT_NORM_FIN: begin
                wr_en   = 1'b1;
                wr_addr = r_count;
                wr_data = ONE_Q;
            end
            default: wr_en = 1'b0;
        endcase
    end

    assign div_start = (i_cmd.act == ACT_NORM_DIV) || (i_cmd.act == ACT_REM_DIV);
    assign div_num   = (i_cmd.act == ACT_NORM_DIV) ? rd_data : num_c;
    assign div_den   = (i_cmd.act == ACT_NORM_DIV) ? r_csum : r_width;

    cdfs_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_quot  (quot),
        .o_done  (div_done)
    );

    // entry zero is never written and always reads as zero
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        r_rd      <= r_mem[rd_addr];
        r_rd_zero <= (rd_addr == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_flag    <= 1'b0;
            r_csum    <= '0;
            r_o_valid <= 1'b0;
        end else begin
            if (i_cmd.act == ACT_RESULT) begin
                r_o_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_o_valid <= 1'b0;
            end
            case (i_cmd.act)
                ACT_LOAD: begin
                    r_op     <= i_op;
                    r_weight <= i_weight;
                    r_sample <= i_sample;
                    r_eidx   <= i_eidx;
                    r_chosen <= '0;
                    r_prob   <= '0;
                    r_remap  <= '0;
                    r_total  <= '0;
                    r_stat   <= ST_OK;
                end
                ACT_CLEAR: begin
                    r_count <= '0;
                    r_flag  <= 1'b0;
                end
                ACT_APPEND_WR: begin
                    r_count <= r_count + 1'b1;
                    if (app_sum[TAB_W]) begin
                        r_stat <= ST_SAT;
                    end
                end
                ACT_NORM_SUM: begin
                    r_csum  <= rd_data;
                    r_total <= rd_data;
                    r_i     <= CNT_W'(1);
                    if (r_count == '0) begin
                        r_stat <= ST_EMPTY;
                    end
                end
                ACT_NORM_WR:  r_i <= r_i + 1'b1;
                ACT_NORM_FIN: r_flag <= 1'b1;
                ACT_SRCH_INIT: begin
                    r_lo <= '0;
                    r_hi <= r_count + 1'b1;
                end
                ACT_SRCH_RD: r_mid <= mid_c;
                ACT_SRCH_CMP: begin
                    if (rd_data < {1'b0, r_sample}) begin
                        r_lo <= r_mid + 1'b1;
                    end else begin
                        r_hi <= r_mid;
                    end
                end
                ACT_PICK_RD0: r_idx <= idx_c;
                ACT_READ_RD0: r_idx <= CNT_W'(r_eidx);
                ACT_PICK_RD1: r_lo_v <= rd_data;
                ACT_PICK_W: begin
                    r_width <= width_c;
                    r_prob  <= width_c;
                    if (r_op == OP_SAMPLE) begin
                        r_chosen <= r_idx[IDX_W-1:0];
                    end
                end
                ACT_REM_SET:   r_remap <= (quot > ONE_Q) ? ONE_Q[SAMP_W-1:0] : quot[SAMP_W-1:0];
                ACT_SET_FULL:  r_stat <= ST_FULL;
                ACT_SET_EMPTY: r_stat <= ST_EMPTY;
                ACT_SET_OOB:   r_stat <= ST_OOB;
                ACT_SET_ZERO:  r_stat <= ST_ZERO;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.act == ACT_RESULT) begin
            r_o_chosen <= r_chosen;
            r_o_prob   <= r_prob;
            r_o_remap  <= r_remap;
            r_o_total  <= r_total;
            r_o_count  <= r_count;
            r_o_flag   <= r_flag;
            r_o_stat   <= r_stat;
        end
    end

    assign o_sts.op         = r_op;
    assign o_sts.cnt_zero   = (r_count == '0);
    assign o_sts.full       = (r_count >= DEPTH_C);
    assign o_sts.sum_zero   = (r_csum == '0);
    assign o_sts.srch_done  = (r_lo >= r_hi);
    assign o_sts.norm_last  = (r_i == r_count);
    assign o_sts.idx_oob    = (CNT_W'(r_eidx) >= r_count);
    assign o_sts.width_zero = (r_width == '0);
    assign o_sts.div_done   = div_done;
    assign o_sts.out_free   = !r_o_valid || i_m_tready;

    assign o_valid  = r_o_valid;
    assign o_chosen = r_o_chosen;
    assign o_prob   = r_o_prob;
    assign o_remap  = r_o_remap;
    assign o_total  = r_o_total;
    assign o_count  = r_o_count;
    assign o_flag   = r_o_flag;
    assign o_stat   = r_o_stat;

endmodule

[src/cdfs_ctrl.sv]
module cdfs_ctrl
    import cdfs_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_s_tvalid,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    typedef enum logic [4:0] {
        S_IDLE, S_DISPATCH, S_APP_WR, S_NORM_SUM, S_NORM_CHK, S_NORM_RD, S_NORM_DIV,
        S_NORM_WAIT, S_NORM_WR, S_NORM_FIN, S_SRCH_RD, S_SRCH_CMP, S_PICK0, S_PICK1,
        S_PICK2, S_REM_CHK, S_REM_WAIT, S_RESULT
    } t_state;

    t_state r_state, n_state;
    t_act   act;

    always_comb begin
        n_state = r_state;
        act     = ACT_NONE;
        unique case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    act     = ACT_LOAD;
                    n_state = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                n_state = S_RESULT;
                unique case (i_sts.op)
                    OP_CLEAR: act = ACT_CLEAR;
                    OP_APPEND: begin
                        if (i_sts.full) begin
                            act = ACT_SET_FULL;
                        end else begin
                            act     = ACT_RD_LAST;
                            n_state = S_APP_WR;
                        end
                    end
                    OP_NORMALIZE: begin
                        act     = ACT_RD_LAST;
                        n_state = S_NORM_SUM;
                    end
                    OP_SAMPLE: begin
                        if (i_sts.cnt_zero) begin
                            act = ACT_SET_EMPTY;
                        end else begin
                            act     = ACT_SRCH_INIT;
                            n_state = S_SRCH_RD;
                        end
                    end
                    OP_READ: begin
                        if (i_sts.cnt_zero) begin
                            act = ACT_SET_EMPTY;
                        end else if (i_sts.idx_oob) begin
                            act = ACT_SET_OOB;
                        end else begin
                            act     = ACT_READ_RD0;
                            n_state = S_PICK1;
                        end
                    end
                    default: act = ACT_NONE;
                endcase
            end
            S_APP_WR: begin
                act     = ACT_APPEND_WR;
                n_state = S_RESULT;
            end
            S_NORM_SUM: begin
                act     = ACT_NORM_SUM;
                n_state = S_NORM_CHK;
            end
            S_NORM_CHK: n_state = (i_sts.cnt_zero || i_sts.sum_zero) ? S_RESULT : S_NORM_RD;
            S_NORM_RD: begin
                act     = ACT_NORM_RD;
                n_state = S_NORM_DIV;
            end
            S_NORM_DIV: begin
                act     = ACT_NORM_DIV;
                n_state = S_NORM_WAIT;
            end
            S_NORM_WAIT: begin
                if (i_sts.div_done) begin
                    n_state = S_NORM_WR;
                end
            end
            S_NORM_WR: begin
                act     = ACT_NORM_WR;
                n_state = i_sts.norm_last ? S_NORM_FIN : S_NORM_RD;
            end
            S_NORM_FIN: begin
                act     = ACT_NORM_FIN;
                n_state = S_RESULT;
            end
            S_SRCH_RD: begin
                if (i_sts.srch_done) begin
                    n_state = S_PICK0;
                end else begin
                    act     = ACT_SRCH_RD;
                    n_state = S_SRCH_CMP;
                end
            end
            S_SRCH_CMP: begin
                act     = ACT_SRCH_CMP;
                n_state = S_SRCH_RD;
            end
            S_PICK0: begin
                act     = ACT_PICK_RD0;
                n_state = S_PICK1;
            end
            S_PICK1: begin
                act     = ACT_PICK_RD1;
                n_state = S_PICK2;
            end
            S_PICK2: begin
                act     = ACT_PICK_W;
                n_state = (i_sts.op == OP_SAMPLE) ? S_REM_CHK : S_RESULT;
            end
            S_REM_CHK: begin
                if (i_sts.width_zero) begin
                    act     = ACT_SET_ZERO;
                    n_state = S_RESULT;
                end else begin
                    act     = ACT_REM_DIV;
                    n_state = S_REM_WAIT;
                end
            end
            S_REM_WAIT: begin
                if (i_sts.div_done) begin
                    act     = ACT_REM_SET;
                    n_state = S_RESULT;
                end
            end
            S_RESULT: begin
                // hold until the output register can take the result
                if (i_sts.out_free) begin
                    act     = ACT_RESULT;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_cmd.act     = act;
    assign o_cmd.s_ready = (r_state == S_IDLE);

endmodule

[src/discrete_cdf_sampler.sv]
// Channel   Direction  Handshake                Contents
// s_axis    in         i_s_tvalid/o_s_tready    tuser: op; tdata: weight, sample, entry index
// m_axis    out        o_m_tvalid/i_m_tready    tdata: index, probability, remap, total,
//                                                      count, normalized flag, status
// One transaction at a time. Sample time is set by the binary search over the table's
// single read port and the bit-serial divider; normalize divides each held entry in turn.
// Reset clears the count, sum and flag; the table needs no clearing pass.
// A waiting result holds in the output register while the next transaction is taken;
// that transaction's result waits in the working registers until the output register is free.
module discrete_cdf_sampler
    import cdfs_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_s_tvalid,
    output logic          o_s_tready,
    input  logic [55:0]   i_s_tdata,  // weight[15:0], sample_value[40:16], entry_index[50:41]
    input  logic [OP_W-1:0] i_s_tuser, // op[2:0]
    output logic          o_m_tvalid,
    input  logic          i_m_tready,
    output logic [103:0]  o_m_tdata   // chosen_index[9:0], probability[35:10],
                                      // remapped_sample[60:36], total[86:61],
                                      // entry_count[97:87], is_normalized[98], status[101:99]
);

    t_cmd cmd;
    t_sts sts;

    logic [IDX_W-1:0]  chosen;
    logic [TAB_W-1:0]  prob, total;
    logic [SAMP_W-1:0] remap;
    logic [CNT_W-1:0]  count;
    logic              flag;
    logic [STAT_W-1:0] stat;

    cdfs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    cdfs_datapath u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .i_op       (i_s_tuser),
        .i_weight   (i_s_tdata[15:0]),
        .i_sample   (i_s_tdata[40:16]),
        .i_eidx     (i_s_tdata[50:41]),
        .i_m_tready (i_m_tready),
        .o_valid    (o_m_tvalid),
        .o_chosen   (chosen),
        .o_prob     (prob),
        .o_remap    (remap),
        .o_total    (total),
        .o_count    (count),
        .o_flag     (flag),
        .o_stat     (stat)
    );

    assign o_s_tready = cmd.s_ready;
    assign o_m_tdata  = {2'b00, stat, flag, count, total, remap, prob, chosen};

endmodule

[bench/discrete_cdf_sampler_test.sv]
module discrete_cdf_sampler_test;
    import cdfs_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic [15:0]     weight;
        logic [24:0]     sample;
        logic [9:0]      entry;
    } t_item;

    typedef struct packed {
        logic [9:0]        index;
        logic [TAB_W-1:0]  prob;
        logic [24:0]       remap;
        logic [TAB_W-1:0]  total;
        logic [CNT_W-1:0]  count;
        logic              normed;
        logic [STAT_W-1:0] status;
    } t_result;

    logic         i_clk;
    logic         i_rst_n;
    logic         i_s_tvalid;
    logic         o_s_tready;
    logic [55:0]  i_s_tdata;  // weight[15:0], sample_value[40:16], entry_index[50:41]
    logic [OP_W-1:0] i_s_tuser; // op[2:0]
    logic         o_m_tvalid;
    logic         i_m_tready;
    logic [103:0] o_m_tdata;  // chosen_index, probability, remap, total, count, flag, status

    discrete_cdf_sampler i_dut (.*);

    // predictor state
    logic [TAB_W-1:0] cdf_tab [0:DEPTH];
    int unsigned      held;
    logic [TAB_W-1:0] cap_sum;
    logic             normed;

    t_item   pending_items[$];
    t_result expected_results[$];
    int      n_errors;
    int      idle_gap_pct;   // 0 during the no-idle stretch
    bit      hold_send;
    int      stall_cycles;
    bit      started;

    function automatic t_result predict_item(t_item it);
        t_result r;
        longint unsigned nxt, v, s, lo, width, num, q, sum;
        int unsigned p, lo_i, hi_i, mid, idx;
        r = '0;
        case (it.op)
            OP_CLEAR: begin
                held = 0;
                cdf_tab[0] = '0;
                normed = 0;
            end
            OP_APPEND: begin
                if (held >= DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    nxt = 64'(cdf_tab[held]) + 64'(it.weight);
                    if (nxt > TAB_MAX) begin
                        nxt = 64'(TAB_MAX);
                        r.status = ST_SAT;
                    end
                    held++;
                    cdf_tab[held] = nxt[TAB_W-1:0];
                end
            end
            OP_NORMALIZE: begin
                sum = 64'(cdf_tab[held]);
                cap_sum = sum[TAB_W-1:0];
                if (held == 0) begin
                    r.status = ST_EMPTY;
                end else if (sum != 0) begin
                    for (int i = 1; i <= held; i++) begin
                        v = (64'(cdf_tab[i]) << FRAC_BITS) / sum;
                        cdf_tab[i] = v > TAB_MAX ? TAB_MAX : v[TAB_W-1:0];
                    end
                    cdf_tab[held] = ONE_Q;
                    normed = 1;
                end
                r.total = cap_sum;
            end
            OP_SAMPLE: begin
                if (held == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    s = 64'(it.sample);
                    lo_i = 0;
                    hi_i = held + 1;
                    while (lo_i < hi_i) begin
                        mid = lo_i + (hi_i - lo_i) / 2;
                        if (64'(cdf_tab[mid]) < s) lo_i = mid + 1;
                        else hi_i = mid;
                    end
                    p = lo_i;
                    idx = p == 0 ? 0 : p - 1;
                    if (idx > held - 1) idx = held - 1;
                    lo = 64'(cdf_tab[idx]);
                    width = 64'(cdf_tab[idx + 1] - cdf_tab[idx]);
                    r.index = idx[9:0];
                    r.prob = width[TAB_W-1:0];
                    if (width == 0) begin
                        r.status = ST_ZERO;
                    end else begin
                        num = s > lo ? s - lo : 64'd0;
                        q = (num << FRAC_BITS) / width;
                        if (q > (64'd1 << FRAC_BITS)) q = 64'd1 << FRAC_BITS;
                        r.remap = q[24:0];
                    end
                end
            end
            OP_READ: begin
                if (held == 0) r.status = ST_EMPTY;
                else if (it.entry >= held) r.status = ST_OOB;
                else r.prob = cdf_tab[it.entry + 1] - cdf_tab[it.entry];
            end
            default: ;
        endcase
        r.count = held[CNT_W-1:0];
        r.normed = normed;
        return r;
    endfunction

    task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        n_errors++;
    endtask

    function automatic t_item mk(logic [OP_W-1:0] op, int unsigned w = 0,
                                 int unsigned s = 0, int unsigned e = 0);
        t_item it;
        it.op = op;
        it.weight = w[15:0];
        it.sample = s[24:0];
        it.entry = e[9:0];
        return it;
    endfunction

    task automatic queue_item(t_item it);
        pending_items.insert(pending_items.size(), it);
    endtask

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    // driver
    always @(posedge i_clk) begin
        t_item it;
        if (!i_rst_n) begin
            i_s_tvalid <= 0;
        end else begin
            if (i_s_tvalid && o_s_tready) begin
                it = pending_items.pop_front();
                expected_results.insert(expected_results.size(), predict_item(it));
            end
            if ((!i_s_tvalid || o_s_tready) ) begin
                if (pending_items.size() > (i_s_tvalid && o_s_tready ? 0 : 0) && started
                    && !hold_send && $urandom_range(99) >= idle_gap_pct
                    && !(i_s_tvalid && o_s_tready && pending_items.size() == 0)) begin
                    i_s_tvalid <= 1;
                    i_s_tdata <= {5'b0, pending_items[0].entry, pending_items[0].sample,
                                  pending_items[0].weight};
                    i_s_tuser <= pending_items[0].op;
                end else begin
                    i_s_tvalid <= 0;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_result got, want;
        if (!i_rst_n) begin
            i_m_tready <= 0;
        end else begin
            if (o_m_tvalid && i_m_tready) begin
                got = o_m_tdata[101:0];
                got = {o_m_tdata[9:0], o_m_tdata[35:10], o_m_tdata[60:36], o_m_tdata[86:61],
                       o_m_tdata[97:87], o_m_tdata[98], o_m_tdata[101:99]};
                if (expected_results.size() == 0) begin
                    report_mismatch("unexpected result", 1, 0);
                end else begin
                    want = expected_results.pop_front();
                    if (got.index != want.index) report_mismatch("index", got.index, want.index);
                    if (got.prob != want.prob) report_mismatch("probability", got.prob, want.prob);
                    if (got.remap != want.remap) report_mismatch("remap", got.remap, want.remap);
                    if (got.total != want.total) report_mismatch("total", got.total, want.total);
                    if (got.count != want.count) report_mismatch("count", got.count, want.count);
                    if (got.normed != want.normed)
                        report_mismatch("normalized", got.normed, want.normed);
                    if (got.status != want.status)
                        report_mismatch("status", got.status, want.status);
                end
            end
            i_m_tready <= $urandom_range(99) >= idle_gap_pct;
        end
    end

    // watchdog: stops with FAIL if no handshake happens on either channel within the stall limit
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles > 200000) begin
                $display("FAIL");
                $finish;
            end
        end
    end

    task automatic add_set(int unsigned n, int unsigned wmax);
        queue_item(mk(OP_CLEAR));
        for (int k = 0; k < n; k++) begin
            queue_item(mk(OP_APPEND, $urandom_range(wmax)));
        end
    endtask

    task automatic add_random_ops(int unsigned n, bit normed_probe);
        int unsigned r;
        for (int k = 0; k < n; k++) begin
            r = $urandom_range(99);
            if (r < 45) begin
                queue_item(mk(OP_SAMPLE, 0,
                    $urandom_range(9) == 0 ? $urandom_range(1 << 24, 0) :
                    (normed_probe ? $urandom_range(1 << 24) : $urandom_range(25'h1FFFFFF))));
            end else if (r < 75) begin
                queue_item(mk(OP_READ, 0, 0,
                    $urandom_range(3) == 0 ? $urandom_range(1023) : $urandom_range(40)));
            end else if (r < 83) begin
                queue_item(mk(OP_APPEND, $urandom_range(65535)));
            end else if (r < 88) begin
                queue_item(mk(OP_NORMALIZE));
            end else if (r < 92) begin
                queue_item(mk(OP_W'($urandom_range(7, 5)), $urandom_range(65535),
                              $urandom_range(25'h1FFFFFF), $urandom_range(1023)));
            end else begin
                queue_item(mk(OP_SAMPLE, 0, $urandom_range(25'h1FFFFFF)));
            end
        end
    endtask

    task automatic wait_drained();
        while (pending_items.size() != 0 || i_s_tvalid || expected_results.size() != 0)
            @(posedge i_clk);
    endtask

    initial begin
        int unsigned n;
        i_rst_n = 0;
        i_s_tvalid = 0;
        i_s_tdata = '0;
        i_s_tuser = OP_CLEAR;
        i_m_tready = 0;
        n_errors = 0;
        idle_gap_pct = 36;
        hold_send = 0;
        started = 0;
        held = 0;
        cap_sum = '0;
        normed = 0;
        cdf_tab[0] = '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1;

        // directed: empty cases, extremes, every op
        queue_item(mk(OP_SAMPLE, 0, 25'h1FFFFFF));
        queue_item(mk(OP_READ, 0, 0, 1023));
        queue_item(mk(OP_NORMALIZE));
        queue_item(mk(OP_APPEND, 0));
        queue_item(mk(OP_APPEND, 0));
        queue_item(mk(OP_NORMALIZE));           // zero sum
        queue_item(mk(OP_SAMPLE, 0, 0));        // zero-width interval
        queue_item(mk(OP_APPEND, 65535));
        queue_item(mk(OP_APPEND, 1));
        queue_item(mk(OP_READ, 0, 0, 2));
        queue_item(mk(OP_READ, 0, 0, 4));       // out of range
        queue_item(mk(OP_SAMPLE, 0, 25'h1FFFFFF)); // above last entry
        queue_item(mk(OP_NORMALIZE));
        queue_item(mk(OP_SAMPLE, 0, 1 << 24));
        queue_item(mk(OP_SAMPLE, 0, 25'h0AAAAAA));
        queue_item(mk(OP_APPEND, 65535));       // append after normalize
        queue_item(mk(OP_READ, 0, 0, 4));
        queue_item(mk(OP_W'(7), 16'hFFFF, 25'h1FFFFFF, 1023));
        queue_item(mk(OP_CLEAR));
        queue_item(mk(OP_NORMALIZE));           // clear empties the table
        started = 1;
        wait_drained();

        // hold the sender until everything is back
        hold_send = 1;
        repeat (50) @(posedge i_clk);
        hold_send = 0;

        // full table: 1030 max weights fill the table, the last six report full
        add_set(1030, 0);
        for (int k = 0; k < 1030; k++) pending_items.pop_back();
        for (int k = 0; k < 1030; k++) queue_item(mk(OP_APPEND, 65535));
        queue_item(mk(OP_READ, 0, 0, 1023));
        queue_item(mk(OP_SAMPLE, 0, 25'h1FFFFFF));
        queue_item(mk(OP_NORMALIZE));
        queue_item(mk(OP_SAMPLE, 0, 25'h0800000));
        queue_item(mk(OP_READ, 0, 0, 1023));
        idle_gap_pct = 0;   // no-idle stretch
        wait_drained();
        idle_gap_pct = 36;

        // random: small tables, random contents, sample and read heavy
        for (int s = 0; s < 10; s++) begin
            n = $urandom_range(3) == 0 ? $urandom_range(40, 1) : $urandom_range(8, 1);
            add_set(n, $urandom_range(1) ? 65535 : 15);
            if ($urandom_range(3) != 0) queue_item(mk(OP_NORMALIZE));
            add_random_ops(25, 1);
            if (s == 5) idle_gap_pct = 0;
            if (s == 7) idle_gap_pct = 36;
        end
        wait_drained();
        repeat (100) @(posedge i_clk);

        if (n_errors == 0 && expected_results.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end
endmodule
